FILE: rtl/lsac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Largest segment after cuts: shared package
// Sizes, payload structs, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lsac_pkg;

  localparam int unsigned MAX_CUTS = 256;
  localparam int unsigned POS_BITS = 32;
  localparam int unsigned IDX_BITS = $clog2(MAX_CUTS);
  localparam int unsigned CNT_BITS = $clog2(MAX_CUTS + 1);

  typedef struct packed {
    logic [POS_BITS-1:0] cut_position;
    logic                new_run;
  } in_t;

  typedef struct packed {
    logic [POS_BITS-1:0] largest_piece;
    logic                rejected;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_SHIFT_INIT,
    ST_SHIFT_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_MAX_INIT,
    ST_MAX_LOOP,
    ST_MAX_RD,
    ST_MAX_CHK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_cur;
    logic rd_prev;
    logic srch;
    logic shift_init;
    logic shift_wr;
    logic insert;
    logic max_init;
    logic max_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic rej;
    logic ge;
    logic eq;
    logic last;
    logic idx_lt_cnt;
    logic idx_gt_slot;
    logic beyond;
  } sts_t;

endpackage

FILE: rtl/lsac_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Largest segment after cuts: controller
// Sequences the search, shift, insert and longest-piece scan of one cut.
// ----------------------------------------------------------------------------
module lsac_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  lsac_pkg::sts_t  sts_i,
  output lsac_pkg::cmd_t  cmd_o
);

  lsac_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsac_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      lsac_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = lsac_pkg::ST_CHECK;
        end
      end
      lsac_pkg::ST_CHECK: begin
        if (sts_i.rej) begin
          state_d = lsac_pkg::ST_MAX_INIT;
        end else if (sts_i.idx_lt_cnt) begin
          state_d = lsac_pkg::ST_SRCH_RD;
        end else begin
          state_d = lsac_pkg::ST_SHIFT_INIT;
        end
      end
      lsac_pkg::ST_SRCH_RD: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = lsac_pkg::ST_SRCH_CHK;
      end
      lsac_pkg::ST_SRCH_CHK: begin
        cmd_o.srch = 1'b1;
        if (sts_i.eq) begin
          state_d = lsac_pkg::ST_MAX_INIT;
        end else if (sts_i.ge || sts_i.last) begin
          state_d = lsac_pkg::ST_SHIFT_INIT;
        end else begin
          state_d = lsac_pkg::ST_SRCH_RD;
        end
      end
      lsac_pkg::ST_SHIFT_INIT: begin
        cmd_o.shift_init = 1'b1;
        state_d          = lsac_pkg::ST_SHIFT_CHK;
      end
      lsac_pkg::ST_SHIFT_CHK: begin
        if (sts_i.idx_gt_slot) begin
          state_d = lsac_pkg::ST_SHIFT_RD;
        end else begin
          state_d = lsac_pkg::ST_INSERT;
        end
      end
      lsac_pkg::ST_SHIFT_RD: begin
        cmd_o.rd_prev = 1'b1;
        state_d       = lsac_pkg::ST_SHIFT_WR;
      end
      lsac_pkg::ST_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = lsac_pkg::ST_SHIFT_CHK;
      end
      lsac_pkg::ST_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d      = lsac_pkg::ST_MAX_INIT;
      end
      lsac_pkg::ST_MAX_INIT: begin
        cmd_o.max_init = 1'b1;
        state_d        = lsac_pkg::ST_MAX_LOOP;
      end
      lsac_pkg::ST_MAX_LOOP: begin
        if (sts_i.idx_lt_cnt) begin
          state_d = lsac_pkg::ST_MAX_RD;
        end else begin
          state_d = lsac_pkg::ST_FINISH;
        end
      end
      lsac_pkg::ST_MAX_RD: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = lsac_pkg::ST_MAX_CHK;
      end
      lsac_pkg::ST_MAX_CHK: begin
        if (sts_i.beyond) begin
          state_d = lsac_pkg::ST_FINISH;
        end else begin
          cmd_o.max_step = 1'b1;
          state_d        = lsac_pkg::ST_MAX_LOOP;
        end
      end
      lsac_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = lsac_pkg::ST_IDLE;
      end
      default: begin
        state_d = lsac_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/lsac_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Largest segment after cuts: datapath
// Sorted cut store, length register, scan index and longest-piece tracking.
// ----------------------------------------------------------------------------
module lsac_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsac_pkg::POS_BITS-1:0] cfg_data_i,
  input  lsac_pkg::in_t                 item_i,
  input  lsac_pkg::cmd_t                cmd_i,
  output lsac_pkg::sts_t                sts_o,
  output logic                          done_o,
  output lsac_pkg::out_t                result_o
);

  logic [lsac_pkg::POS_BITS-1:0] mem_q [lsac_pkg::MAX_CUTS];

  logic [lsac_pkg::POS_BITS-1:0] len_q;
  logic [lsac_pkg::CNT_BITS-1:0] cnt_q;
  logic                          done_q;
  logic [lsac_pkg::POS_BITS-1:0] pos_q;
  logic [lsac_pkg::POS_BITS-1:0] rdata_q;
  logic [lsac_pkg::POS_BITS-1:0] prev_q;
  logic [lsac_pkg::POS_BITS-1:0] best_q;
  logic [lsac_pkg::CNT_BITS-1:0] idx_q;
  logic [lsac_pkg::CNT_BITS-1:0] slot_q;
  logic                          rej_q;
  lsac_pkg::out_t                res_q;

  logic [lsac_pkg::CNT_BITS-1:0] cnt_eff;
  logic [lsac_pkg::CNT_BITS-1:0] idx_m1;
  logic [lsac_pkg::IDX_BITS-1:0] raddr;
  logic [lsac_pkg::IDX_BITS-1:0] waddr;
  logic [lsac_pkg::POS_BITS-1:0] wdata;
  logic [lsac_pkg::POS_BITS-1:0] gap;
  logic [lsac_pkg::POS_BITS-1:0] tail;
  logic                          we;
  logic                          early_rej;

  assign cnt_eff   = item_i.new_run ? '0 : cnt_q;
  assign early_rej = (item_i.cut_position == '0) || (item_i.cut_position >= len_q) ||
                     (cnt_eff >= lsac_pkg::CNT_BITS'(lsac_pkg::MAX_CUTS));
  assign idx_m1    = idx_q - lsac_pkg::CNT_BITS'(1);
  assign raddr     = cmd_i.rd_prev ? idx_m1[lsac_pkg::IDX_BITS-1:0]
                                   : idx_q[lsac_pkg::IDX_BITS-1:0];
  assign we        = cmd_i.shift_wr || cmd_i.insert;
  assign waddr     = cmd_i.insert ? slot_q[lsac_pkg::IDX_BITS-1:0]
                                  : idx_q[lsac_pkg::IDX_BITS-1:0];
  assign wdata     = cmd_i.insert ? pos_q : rdata_q;
  assign gap       = rdata_q - prev_q;
  assign tail      = len_q - prev_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_cur || cmd_i.rd_prev) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= lsac_pkg::POS_BITS'(1);
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cfg_we_i) begin
        len_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        cnt_q <= cnt_eff;
      end else if (cmd_i.insert) begin
        cnt_q <= cnt_q + lsac_pkg::CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q  <= item_i.cut_position;
      rej_q  <= early_rej;
      idx_q  <= '0;
      slot_q <= cnt_eff;
    end
    if (cmd_i.srch) begin
      if (rdata_q >= pos_q) begin
        slot_q <= idx_q;
        rej_q  <= (rdata_q == pos_q);
      end else begin
        idx_q <= idx_q + lsac_pkg::CNT_BITS'(1);
      end
    end
    if (cmd_i.shift_init) begin
      idx_q <= cnt_q;
    end
    if (cmd_i.shift_wr) begin
      idx_q <= idx_m1;
    end
    if (cmd_i.max_init) begin
      idx_q  <= '0;
      prev_q <= '0;
      best_q <= '0;
    end
    if (cmd_i.max_step) begin
      idx_q  <= idx_q + lsac_pkg::CNT_BITS'(1);
      prev_q <= rdata_q;
      if (gap > best_q) begin
        best_q <= gap;
      end
    end
    if (cmd_i.finish) begin
      res_q.largest_piece <= (tail > best_q) ? tail : best_q;
      res_q.rejected      <= rej_q;
    end
  end

  assign sts_o.rej         = rej_q;
  assign sts_o.ge          = rdata_q >= pos_q;
  assign sts_o.eq          = rdata_q == pos_q;
  assign sts_o.last        = (idx_q + lsac_pkg::CNT_BITS'(1)) >= cnt_q;
  assign sts_o.idx_lt_cnt  = idx_q < cnt_q;
  assign sts_o.idx_gt_slot = idx_q > slot_q;
  assign sts_o.beyond      = rdata_q >= len_q;

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lsac_pkg::CNT_BITS'(lsac_pkg::MAX_CUTS))
    else $error("cut count exceeds store depth");

  a_insert_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> (!rej_q && cnt_q < lsac_pkg::CNT_BITS'(lsac_pkg::MAX_CUTS)))
    else $error("insert of a rejected cut or into a full store");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> done_q)
    else $error("finished transaction produced no result strobe");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_wr |-> (idx_q > slot_q && idx_q <= cnt_q))
    else $error("shift writes outside the occupied range");
`endif

endmodule

FILE: rtl/largest_segment_after_cuts_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Largest segment after cuts: top level
// Keeps a sorted set of cuts on a line and reports the longest piece.
//
// Usage: drive item_i and raise start; the transaction is taken at an edge
// where start is high and busy is low. Exactly one result per transaction is
// shown on result_o for one cycle, marked by done_o, and cannot be stalled.
// The line length is written on the cfg channel (cfg_valid_i / cfg_ready_o),
// which is ready whenever busy and start are both low.
// A new cut is searched for in the store, the cuts above its slot are moved up
// and it is inserted before the longest-piece scan; a duplicate skips the move
// and the insert, and a cut rejected on range or a full store goes straight to
// the scan. The longest-piece scan stops early at the first stored cut at or
// beyond the length. One transaction is in flight at a time, so the next one
// is taken at the earliest on the edge that takes the result. The run time is
// set by the cut store, which is read at most once per stored cut in the search
// and the longest-piece scan and is read and written for every cut that the
// insert moves up.
// Reset empties the cut set and sets the length to 1; the store contents
// themselves are not cleared.
// ----------------------------------------------------------------------------
module largest_segment_after_cuts_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lsac_pkg::POS_BITS-1:0] cfg_data_i,
  input  logic                          start,
  output logic                          busy,
  input  lsac_pkg::in_t                 item_i,
  output logic                          done_o,
  output lsac_pkg::out_t                result_o
);

  lsac_pkg::cmd_t cmd;
  lsac_pkg::sts_t sts;

  assign cfg_ready_o = !busy && !start;

  lsac_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  lsac_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule
